@@ design/dhac_pkg.sv @@
// ----------------------------------------------------------------------------
// dhac_pkg: shared types and constants of the dual hysteresis alert classifier
// Payload structs, configuration layout, register indexes and level codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dhac_pkg;

  // Widths fixed by the field definitions.
  localparam int TEMP_W   = 11;
  localparam int THYST_W  = 10;
  localparam int LIGHT_W  = 7;
  localparam int LEVEL_W  = 2;
  localparam int AGREE_W  = 4;
  localparam int ESC_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Common signed width for the threshold compares: holds a temperature
  // threshold minus the largest hysteresis without wrapping.
  localparam int CMP_W = 13;

  // Level codes.
  localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARN   = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_ALERT  = 2'd2;

  // Agree count saturates here.
  localparam logic [AGREE_W-1:0] AGREE_MAX = 4'd15;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_ALERT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HYST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_WARN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_ALERT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_HYST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 3'd6;

  // Register reset values.
  localparam logic signed [TEMP_W-1:0] TEMP_WARN_RST  = 11'sd448;
  localparam logic signed [TEMP_W-1:0] TEMP_ALERT_RST = 11'sd512;
  localparam logic [THYST_W-1:0]       TEMP_HYST_RST  = 10'd32;
  localparam logic [LIGHT_W-1:0]       LIGHT_WARN_RST  = 7'd60;
  localparam logic [LIGHT_W-1:0]       LIGHT_ALERT_RST = 7'd75;
  localparam logic [LIGHT_W-1:0]       LIGHT_HYST_RST  = 7'd5;
  localparam logic [AGREE_W-1:0]       CONFIRM_RST     = 4'd3;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_q4;
    logic [LIGHT_W-1:0]       light_percent;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] temp_level;
    logic [LEVEL_W-1:0] light_level;
    logic [LEVEL_W-1:0] overall_level;
    logic               overall_changed;
    logic [ESC_W-1:0]   temp_escalations;
    logic [ESC_W-1:0]   light_escalations;
  } out_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_warn_level;
    logic signed [TEMP_W-1:0] temp_alert_level;
    logic [THYST_W-1:0]       temp_step_margin;
    logic [LIGHT_W-1:0]       light_warn_level;
    logic [LIGHT_W-1:0]       light_alert_level;
    logic [LIGHT_W-1:0]       light_hysteresis;
    logic [AGREE_W-1:0]       confirm_count;
  } cfg_t;

  // Per-channel step result handed to the top level.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               rise;
  } chan_res_t;

endpackage

`default_nettype wire

@@ design/dual_hysteresis_alert_classifier_core.sv @@
// ----------------------------------------------------------------------------
// dual_hysteresis_alert_classifier_core: temperature and light alert levels
// Each accepted word passes through the input register and then the result
// register, and can wait in either while the receiver stalls.
// Throughput: one word per cycle while the result register is not stalled.
// Reset: synchronous, active high; clears all levels, counts and counters and
// restores the register defaults. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_hysteresis_alert_classifier_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire dhac_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output dhac_pkg::out_t                        out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dhac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dhac_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dhac_pkg::*;

  // The design is a two-register pipeline. The input register captures each
  // accepted word; the classification, debounce and counter updates then run
  // in one pass of short logic and land in the result register. Channel state
  // is updated in the same cycle, so the next word in the input register sees
  // the state its predecessor left behind.

  cfg_t cfg;

  dhac_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  logic s1_valid;
  in_t  s1_data;
  logic advance;

  // The word in the input register moves on whenever the result register is
  // empty or is being emptied in this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // Both channels compare in a common signed width, wide enough that a
  // threshold minus its hysteresis never wraps.
  logic signed [CMP_W-1:0] t_sample, t_warn, t_alert, t_hyst;
  logic signed [CMP_W-1:0] l_sample, l_warn, l_alert, l_hyst;

  assign t_sample = CMP_W'(s1_data.temperature_q4);
  assign t_warn   = CMP_W'(cfg.temp_warn_level);
  assign t_alert  = CMP_W'(cfg.temp_alert_level);
  assign t_hyst   = $signed({{(CMP_W-THYST_W){1'b0}}, cfg.temp_step_margin});
  assign l_sample = $signed({{(CMP_W-LIGHT_W){1'b0}}, s1_data.light_percent});
  assign l_warn   = $signed({{(CMP_W-LIGHT_W){1'b0}}, cfg.light_warn_level});
  assign l_alert  = $signed({{(CMP_W-LIGHT_W){1'b0}}, cfg.light_alert_level});
  assign l_hyst   = $signed({{(CMP_W-LIGHT_W){1'b0}}, cfg.light_hysteresis});

  chan_res_t t_res, l_res;

  dhac_channel u_temp (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (t_sample),
    .warn    (t_warn),
    .alert   (t_alert),
    .hyst    (t_hyst),
    .confirm (cfg.confirm_count),
    .res     (t_res)
  );

  dhac_channel u_light (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (l_sample),
    .warn    (l_warn),
    .alert   (l_alert),
    .hyst    (l_hyst),
    .confirm (cfg.confirm_count),
    .res     (l_res)
  );

  // Overall level tracking and the wrapping escalation counters.
  logic [LEVEL_W-1:0] overall_state, overall_next;
  logic [ESC_W-1:0]   temp_rise_total, temp_rise_total_next;
  logic [ESC_W-1:0]   light_rise_total, light_rise_total_next;

  assign overall_next = (t_res.level > l_res.level) ? t_res.level : l_res.level;
  assign temp_rise_total_next  = temp_rise_total + ESC_W'(t_res.rise);
  assign light_rise_total_next = light_rise_total + ESC_W'(l_res.rise);

  always_ff @(posedge clk) begin
    if (rst) begin
      overall_state    <= LVL_NORMAL;
      temp_rise_total  <= '0;
      light_rise_total <= '0;
    end else if (advance) begin
      overall_state    <= overall_next;
      temp_rise_total  <= temp_rise_total_next;
      light_rise_total <= light_rise_total_next;
    end
  end

  // Result register: it holds a finished word while the input register can still
  // take one more; once both are full, a receiver stall holds off in_ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.temp_level        <= t_res.level;
      out_data.light_level       <= l_res.level;
      out_data.overall_level     <= overall_next;
      out_data.overall_changed   <= (overall_next != overall_state);
      out_data.temp_escalations  <= temp_rise_total_next;
      out_data.light_escalations <= light_rise_total_next;
    end
  end

endmodule

`default_nettype wire

@@ design/dhac_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dhac_cfg_regs: configuration register file
// Holds the thresholds, hysteresis margins and confirm count.
// ----------------------------------------------------------------------------
`default_nettype none

module dhac_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dhac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dhac_pkg::CFG_DATA_W-1:0] cfg_data,
  output dhac_pkg::cfg_t                     cfg
);
  import dhac_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_warn_level   <= TEMP_WARN_RST;
      cfg.temp_alert_level  <= TEMP_ALERT_RST;
      cfg.temp_step_margin  <= TEMP_HYST_RST;
      cfg.light_warn_level  <= LIGHT_WARN_RST;
      cfg.light_alert_level <= LIGHT_ALERT_RST;
      cfg.light_hysteresis  <= LIGHT_HYST_RST;
      cfg.confirm_count     <= CONFIRM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEMP_WARN:   cfg.temp_warn_level   <= $signed(cfg_data[TEMP_W-1:0]);
        REG_TEMP_ALERT:  cfg.temp_alert_level  <= $signed(cfg_data[TEMP_W-1:0]);
        REG_TEMP_HYST:   cfg.temp_step_margin  <= cfg_data[THYST_W-1:0];
        REG_LIGHT_WARN:  cfg.light_warn_level  <= cfg_data[LIGHT_W-1:0];
        REG_LIGHT_ALERT: cfg.light_alert_level <= cfg_data[LIGHT_W-1:0];
        REG_LIGHT_HYST:  cfg.light_hysteresis  <= cfg_data[LIGHT_W-1:0];
        REG_CONFIRM:     cfg.confirm_count     <= cfg_data[AGREE_W-1:0];
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/dhac_channel.sv @@
// ----------------------------------------------------------------------------
// dhac_channel: one three-level hysteresis classifier with debounce
// Holds the accepted level, the pending candidate and its agree count.
// ----------------------------------------------------------------------------
`default_nettype none

module dhac_channel (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                advance,
  input  wire logic signed [dhac_pkg::CMP_W-1:0]   sample,
  input  wire logic signed [dhac_pkg::CMP_W-1:0]   warn,
  input  wire logic signed [dhac_pkg::CMP_W-1:0]   alert,
  input  wire logic signed [dhac_pkg::CMP_W-1:0]   hyst,
  input  wire logic [dhac_pkg::AGREE_W-1:0]        confirm,
  output dhac_pkg::chan_res_t                      res
);
  import dhac_pkg::*;

  logic [LEVEL_W-1:0] level, level_next;
  logic [LEVEL_W-1:0] pending, pending_next;
  logic [AGREE_W-1:0] agree, agree_next;
  logic [LEVEL_W-1:0] cand;
  logic [AGREE_W-1:0] agree_inc;
  logic signed [CMP_W-1:0] warn_down, alert_down;

  assign warn_down  = warn - hyst;
  assign alert_down = alert - hyst;

  // Candidate level: at most one step per word.
  always_comb begin
    cand = level;
    unique case (level)
      LVL_NORMAL: begin
        if (sample >= warn) cand = LVL_WARN;
      end
      LVL_WARN: begin
        if (sample >= alert)         cand = LVL_ALERT;
        else if (sample < warn_down) cand = LVL_NORMAL;
      end
      default: begin
        if (sample < alert_down) cand = LVL_WARN;
      end
    endcase
  end

  assign agree_inc = (agree < AGREE_MAX) ? agree + 1'b1 : agree;

  // Debounce: a differing candidate must repeat until the count reaches confirm.
  always_comb begin
    level_next   = level;
    pending_next = pending;
    agree_next   = agree;
    if (cand == level) begin
      agree_next   = '0;
      pending_next = level;
    end else if (cand == pending) begin
      if (agree_inc >= confirm) begin
        agree_next = '0;
        level_next = cand;
      end else begin
        agree_next = agree_inc;
      end
    end else begin
      pending_next = cand;
      agree_next   = AGREE_W'(1);
    end
  end

  assign res.level = level_next;
  assign res.rise  = (level_next > level);

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= LVL_NORMAL;
      pending <= LVL_NORMAL;
      agree   <= '0;
    end else if (advance) begin
      level   <= level_next;
      pending <= pending_next;
      agree   <= agree_next;
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_dual_hysteresis_alert_classifier_core.sv @@
// ----------------------------------------------------------------------------
// tb_dual_hysteresis_alert_classifier_core: self-checking bench for the core
// Drives sample words through valid/ready with random gaps and stalls, keeps
// its own copy of the two-channel classifier with debounce, and compares every
// result word field by field against the predicted levels and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dual_hysteresis_alert_classifier_core;
  import dhac_pkg::*;

  // Index 7 is decoded by nothing; a write to it must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Field ranges used when building sample words.
  localparam int TEMP_MIN  = -(1 << (TEMP_W - 1));
  localparam int TEMP_MAX  = (1 << (TEMP_W - 1)) - 1;
  localparam int LIGHT_MAX = (1 << LIGHT_W) - 1;

  // The longest quiet spell of a correct run is a long sender gap plus a long
  // receiver stall plus the trip through the two registers, well under the limit.
  localparam int QUIET_LIMIT = 1000;

  // Debounce state of one channel.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] pending;
    logic [AGREE_W-1:0] agree;
  } chan_state_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  in_t    in_data = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  out_t   out_data;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Settings as the bench believes the core holds them.
  int                 temp_warn_cfg;
  int                 temp_alert_cfg;
  int                 temp_hyst_cfg;
  int                 light_warn_cfg;
  int                 light_alert_cfg;
  int                 light_hyst_cfg;
  logic [AGREE_W-1:0] confirm_need;

  // Predicted classifier state.
  chan_state_t        temp_chan;
  chan_state_t        light_chan;
  logic [LEVEL_W-1:0] overall_now;
  logic [ESC_W-1:0]   temp_rises;
  logic [ESC_W-1:0]   light_rises;

  // Result words still owed by the core, oldest first.
  out_t expected_levels[$];

  int send_idle_pct = 0;
  int sink_idle_pct = 0;
  int sink_hold = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int register_writes = 0;

  dual_hysteresis_alert_classifier_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic void reset_classifier();
    temp_warn_cfg   = TEMP_WARN_RST;
    temp_alert_cfg  = TEMP_ALERT_RST;
    temp_hyst_cfg   = TEMP_HYST_RST;
    light_warn_cfg  = LIGHT_WARN_RST;
    light_alert_cfg = LIGHT_ALERT_RST;
    light_hyst_cfg  = LIGHT_HYST_RST;
    confirm_need    = CONFIRM_RST;
    temp_chan   = '{level: LVL_NORMAL, pending: LVL_NORMAL, agree: '0};
    light_chan  = '{level: LVL_NORMAL, pending: LVL_NORMAL, agree: '0};
    overall_now = LVL_NORMAL;
    temp_rises  = '0;
    light_rises = '0;
  endfunction

  // Temperature settings are sign-extended from eleven bits; the others are
  // unsigned and taken from the low bits of the data word.
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TEMP_WARN:   temp_warn_cfg   = $signed(data[TEMP_W-1:0]);
      REG_TEMP_ALERT:  temp_alert_cfg  = $signed(data[TEMP_W-1:0]);
      REG_TEMP_HYST:   temp_hyst_cfg   = data[THYST_W-1:0];
      REG_LIGHT_WARN:  light_warn_cfg  = data[LIGHT_W-1:0];
      REG_LIGHT_ALERT: light_alert_cfg = data[LIGHT_W-1:0];
      REG_LIGHT_HYST:  light_hyst_cfg  = data[LIGHT_W-1:0];
      REG_CONFIRM:     confirm_need    = data[AGREE_W-1:0];
      default: ;
    endcase
  endfunction

  // One hysteresis step: up when the sample reaches the next threshold, down
  // when it falls below the current threshold less the margin. The step-down
  // point is worked out in full integer width, so it may be negative.
  function automatic logic [LEVEL_W-1:0] pick_candidate(int sample,
                                                        logic [LEVEL_W-1:0] cur,
                                                        int warn, int alert,
                                                        int hyst);
    pick_candidate = cur;
    case (cur)
      LVL_NORMAL: if (sample >= warn) pick_candidate = LVL_WARN;
      LVL_WARN: begin
        if (sample >= alert) pick_candidate = LVL_ALERT;
        else if (sample < warn - hyst) pick_candidate = LVL_NORMAL;
      end
      default: if (sample < alert - hyst) pick_candidate = LVL_WARN;
    endcase
  endfunction

  // A fresh candidate only opens a count of one, so even a confirm count of
  // zero or one needs a repeat before the level moves.
  function automatic chan_state_t debounce_chan(chan_state_t st,
                                                logic [LEVEL_W-1:0] cand);
    chan_state_t nx;
    nx = st;
    if (cand == st.level) begin
      nx.agree   = '0;
      nx.pending = st.level;
    end else if (cand == st.pending) begin
      if (st.agree != AGREE_MAX) nx.agree = st.agree + 1'b1;
      if (nx.agree >= confirm_need) begin
        nx.agree = '0;
        nx.level = cand;
      end
    end else begin
      nx.pending = cand;
      nx.agree   = 4'd1;
    end
    return nx;
  endfunction

  function automatic out_t advance_classifier(in_t s);
    int                 t_sample;
    int                 l_sample;
    logic [LEVEL_W-1:0] t_prev;
    logic [LEVEL_W-1:0] l_prev;
    logic [LEVEL_W-1:0] top;
    out_t               r;
    t_sample = $signed(s.temperature_q4);
    l_sample = s.light_percent;
    t_prev = temp_chan.level;
    l_prev = light_chan.level;
    temp_chan = debounce_chan(temp_chan, pick_candidate(t_sample, temp_chan.level,
                              temp_warn_cfg, temp_alert_cfg, temp_hyst_cfg));
    light_chan = debounce_chan(light_chan, pick_candidate(l_sample, light_chan.level,
                               light_warn_cfg, light_alert_cfg, light_hyst_cfg));
    top = (temp_chan.level > light_chan.level) ? temp_chan.level : light_chan.level;
    if (temp_chan.level > t_prev) temp_rises++;
    if (light_chan.level > l_prev) light_rises++;
    r.temp_level        = temp_chan.level;
    r.light_level       = light_chan.level;
    r.overall_level     = top;
    r.overall_changed   = (top != overall_now);
    r.temp_escalations  = temp_rises;
    r.light_escalations = light_rises;
    overall_now = top;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitoring and checking
  // --------------------------------------------------------------------------

  // Every handshake is sampled at the edge, before the nonblocking updates of
  // that edge land, so the bench and the core see the same values.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) expected_levels.push_back(advance_classifier(in_data));
    if (!rst && cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
  end

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        $error("result word arrived with nothing expected");
        fail_count++;
      end else begin
        want = expected_levels.pop_front();
        check_field("temp_level", want.temp_level, out_data.temp_level);
        check_field("light_level", want.light_level, out_data.light_level);
        check_field("overall_level", want.overall_level, out_data.overall_level);
        check_field("overall_changed", want.overall_changed, out_data.overall_changed);
        check_field("temp_escalations", want.temp_escalations, out_data.temp_escalations);
        check_field("light_escalations", want.light_escalations,
                    out_data.light_escalations);
        results_checked++;
      end
    end
  end

  // The run is stopped if no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Idle length before a word or during a stall: mostly none, sometimes short,
  // now and then a long spell.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Receiver side: ready is withdrawn for random stretches.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= 1'b1;
      sink_hold <= pick_gap(sink_idle_pct);
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Valid is left high after acceptance so that back-to-back words need no
  // second assignment in the same step; it drops when a gap is chosen or in wait_idle.
  task automatic send_sample(int t, int l);
    int  t_fit;
    int  l_fit;
    int  gap;
    in_t s;
    t_fit = clamp(t, TEMP_MIN, TEMP_MAX);
    l_fit = clamp(l, 0, LIGHT_MAX);
    s.temperature_q4 = t_fit[TEMP_W-1:0];
    s.light_percent  = l_fit[LIGHT_W-1:0];
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Holds the sender off until every owed result has been seen, then idles on
  // to cover the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    register_writes++;
  endtask

  task automatic program_registers(int tw, int ta, int th, int lw, int la, int lh, int cc);
    write_register(REG_TEMP_WARN, tw);
    write_register(REG_TEMP_ALERT, ta);
    write_register(REG_TEMP_HYST, th);
    write_register(REG_LIGHT_WARN, lw);
    write_register(REG_LIGHT_ALERT, la);
    write_register(REG_LIGHT_HYST, lh);
    write_register(REG_CONFIRM, cc);
  endtask

  // Mostly runs of near-identical samples, most parked around a threshold or a
  // step-down point, of random length up to the confirm count plus two, so some
  // get through the debounce; the rest are single words with every bit random.
  // One pause for a full drain falls at a random point in each phase.
  task automatic run_random_phase(int count, int send_pct, int sink_pct);
    int first;
    int pause_at;
    int t_base;
    int l_base;
    int len;
    @(posedge clk);
    send_idle_pct = send_pct;
    sink_idle_pct = sink_pct;
    first    = samples_sent;
    pause_at = first + $urandom_range(count - 1);
    while (samples_sent - first < count) begin
      if (pause_at >= 0 && samples_sent >= pause_at) begin
        wait_idle();
        pause_at = -1;
      end
      if ($urandom_range(9) < 2) begin
        send_sample(int'($urandom_range(2047)) + TEMP_MIN, int'($urandom_range(LIGHT_MAX)));
      end else begin
        case ($urandom_range(4))
          0: t_base = temp_warn_cfg;
          1: t_base = temp_alert_cfg;
          2: t_base = temp_warn_cfg - temp_hyst_cfg;
          3: t_base = temp_alert_cfg - temp_hyst_cfg;
          default: t_base = int'($urandom_range(2047)) + TEMP_MIN;
        endcase
        case ($urandom_range(4))
          0: l_base = light_warn_cfg;
          1: l_base = light_alert_cfg;
          2: l_base = light_warn_cfg - light_hyst_cfg;
          3: l_base = light_alert_cfg - light_hyst_cfg;
          default: l_base = int'($urandom_range(LIGHT_MAX));
        endcase
        t_base += int'($urandom_range(4)) - 2;
        l_base += int'($urandom_range(4)) - 2;
        len = $urandom_range(confirm_need + 2, 1);
        repeat (len)
          send_sample(t_base + int'($urandom_range(2)) - 1,
                      l_base + int'($urandom_range(2)) - 1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings, no idling: both fields at their extremes, with light well
  // above a hundred, walking both channels up to alert and back to normal.
  task automatic test_level_extremes();
    send_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (6) send_sample(TEMP_MAX, LIGHT_MAX);
    repeat (6) send_sample(TEMP_MIN, 0);
  endtask

  // A confirm count of zero still needs one repeat. The write to the spare
  // index carries all ones, which would show up at once if it reached any
  // real setting.
  task automatic test_confirm_zero_and_spare_index();
    wait_idle();
    write_register(REG_CONFIRM, 0);
    write_register(REG_SPARE, 2047);
    send_idle_pct = 30;
    sink_idle_pct = 30;
    repeat (2) send_sample(0, 100);
    send_sample(0, 0);
    repeat (2) send_sample(0, 101);
  endtask

  // Alert below warning on both channels, margins larger than the thresholds
  // so that the step-down points go negative, and a confirm count of one.
  task automatic test_odd_thresholds();
    wait_idle();
    program_registers(100, -100, 1023, 40, 20, 100, 1);
    send_idle_pct = 10;
    sink_idle_pct = 50;
    repeat (4) send_sample(100, 40);
    repeat (4) send_sample(TEMP_MIN, 0);
  endtask

  task automatic test_random_defaults();
    wait_idle();
    program_registers(TEMP_WARN_RST, TEMP_ALERT_RST, TEMP_HYST_RST, LIGHT_WARN_RST,
                      LIGHT_ALERT_RST, LIGHT_HYST_RST, CONFIRM_RST);
    run_random_phase(150, 20, 20);
  endtask

  // Every setting at its lowest, then every setting at its highest; the
  // second also lets the agree count climb all the way to fifteen.
  task automatic test_random_extremes();
    wait_idle();
    program_registers(TEMP_MIN, TEMP_MIN, 0, 0, 0, 0, 0);
    run_random_phase(120, 0, 0);
    wait_idle();
    program_registers(TEMP_MAX, TEMP_MAX, (1 << THYST_W) - 1, LIGHT_MAX, LIGHT_MAX,
                      LIGHT_MAX, AGREE_MAX);
    run_random_phase(150, 40, 10);
  endtask

  // Random settings: thresholds sometimes inverted, margins mostly small,
  // confirm counts mostly short so that levels keep moving.
  task automatic test_random_settings();
    int tw;
    int ta;
    int lw;
    int la;
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      tw = int'($urandom_range(1023)) - 512;
      ta = ($urandom_range(3) == 0) ? tw - int'($urandom_range(64))
                                    : tw + int'($urandom_range(128));
      lw = $urandom_range(110);
      la = ($urandom_range(3) == 0) ? lw - int'($urandom_range(20))
                                    : lw + int'($urandom_range(30));
      program_registers(tw, clamp(ta, TEMP_MIN, TEMP_MAX),
                        ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(40),
                        lw, clamp(la, 0, LIGHT_MAX),
                        ($urandom_range(3) == 0) ? $urandom_range(LIGHT_MAX)
                                                 : $urandom_range(20),
                        ($urandom_range(3) == 0) ? $urandom_range(AGREE_MAX)
                                                 : $urandom_range(4, 1));
      write_register(REG_SPARE, $urandom_range(2047));
      run_random_phase(160, k * 15, 45 - k * 15);
    end
  endtask

  initial begin
    reset_classifier();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_level_extremes();
    test_confirm_zero_and_spare_index();
    test_odd_thresholds();
    test_random_defaults();
    test_random_extremes();
    test_random_settings();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("Sent %0d sample words, checked %0d result words, made %0d register writes.",
             samples_sent, results_checked, register_writes);
    $display("Settings covered: reset values, all-low, all-high, inverted and random.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
design/dhac_pkg.sv
design/dhac_cfg_regs.sv
design/dhac_channel.sv
design/dual_hysteresis_alert_classifier_core.sv
bench/tb_dual_hysteresis_alert_classifier_core.sv
